FILE: rtl/sep_pkg.sv
// Shared types and constants for the set partition enumerator.
// Holds field widths, the sequencer state type and the store write request.
// No dependencies.
`default_nettype none

package sep_pkg;

  localparam int DIG_W     = 4;   // one restricted growth digit or bound
  localparam int DIGITS_W  = 64;  // packed digit output
  localparam int DIG_IDX_W = 6;   // bit index into the packed digits
  localparam int SEQ_W     = 34;  // sequence number
  localparam int CFG_W     = 5;   // set size register

  localparam logic [CFG_W-1:0] SET_SIZE_RESET = 5'd2;
  localparam logic [CFG_W-1:0] SET_SIZE_MIN   = 5'd2;
  localparam logic [DIG_W-1:0] BOUND_RESET    = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_WRITE
  } sep_state_e;

  // Write request into the digit and bound stores (address travels separately).
  typedef struct packed {
    logic             dig_en;
    logic             bnd_en;
    logic [DIG_W-1:0] dig;
    logic [DIG_W-1:0] bnd;
  } sep_wr_t;

endpackage

`default_nettype wire

FILE: rtl/sep_store.sv
// Digit and bound stores: two synchronous memories with registered read data.
// Per-entry valid bits make a cleared entry read as its reset value.
// Depends on sep_pkg.
`default_nettype none

module sep_store
  import sep_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clr_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire sep_wr_t          wr_i,
  output logic      [DIG_W-1:0] rd_dig_o,
  output logic      [DIG_W-1:0] rd_bnd_o
);

  logic [DIG_W-1:0] dig_mem [DEPTH];
  logic [DIG_W-1:0] bnd_mem [DEPTH];
  logic [DEPTH-1:0] dig_vld_q, dig_vld_d;
  logic [DEPTH-1:0] bnd_vld_q, bnd_vld_d;
  logic [DIG_W-1:0] rd_dig_q, rd_bnd_q;
  logic             rd_dig_vld_q, rd_bnd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.dig_en) begin
      dig_mem[wr_addr_i] <= wr_i.dig;
    end
    if (wr_i.bnd_en) begin
      bnd_mem[wr_addr_i] <= wr_i.bnd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_dig_q <= dig_mem[rd_addr_i];
      rd_bnd_q <= bnd_mem[rd_addr_i];
    end
  end

  always_comb begin
    dig_vld_d = dig_vld_q;
    bnd_vld_d = bnd_vld_q;
    if (clr_i) begin
      dig_vld_d = '0;
      bnd_vld_d = '0;
    end else begin
      if (wr_i.dig_en) dig_vld_d[wr_addr_i] = 1'b1;
      if (wr_i.bnd_en) bnd_vld_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_vld_q    <= '0;
      bnd_vld_q    <= '0;
      rd_dig_vld_q <= 1'b0;
      rd_bnd_vld_q <= 1'b0;
    end else begin
      dig_vld_q <= dig_vld_d;
      bnd_vld_q <= bnd_vld_d;
      if (rd_en_i) begin
        rd_dig_vld_q <= dig_vld_q[rd_addr_i];
        rd_bnd_vld_q <= bnd_vld_q[rd_addr_i];
      end
    end
  end

  // Unwritten entries read as all-zero digits and bounds of one.
  assign rd_dig_o = rd_dig_vld_q ? rd_dig_q : '0;
  assign rd_bnd_o = rd_bnd_vld_q ? rd_bnd_q : BOUND_RESET;

endmodule

`default_nettype wire

FILE: rtl/set_partition_enumerator_top.sv
// Top level of the set partition enumerator: sequencer, scan and write-back datapath.
// Instantiates sep_store; depends on sep_pkg.
//
//   channel   dir  handshake                  payload
//   in        in   in_valid_i / in_ready_o     restart_i
//   out       out  out_valid_o / out_ready_i   growth_digits_o, sequence_number_o,
//                                              is_last_o, exhausted_o
//   cfg       in   cfg_we_i                    cfg_wdata_i (set size)
//
// One request takes an accept step, a scan of the stores from digit n down to digit 1
// through the single read port, an emit step and, unless that string was the last, a
// write-back from the changed digit up to digit n through the single write port.
// A request after exhaustion skips the scan and goes straight to emit.
// Reset and restart clear the stores at once through per-entry valid bits.
// The emit cycle holds while the output register is full and not taken.
`default_nettype none

module set_partition_enumerator_top
  import sep_pkg::*;
#(
  parameter int MAX_N = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                restart_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [DIGITS_W-1:0] growth_digits_o,
  output logic      [SEQ_W-1:0]    sequence_number_o,
  output logic                     is_last_o,
  output logic                     exhausted_o
);

  localparam int AW = $clog2(MAX_N);
  localparam logic [CFG_W-1:0] MaxNCfg = CFG_W'(MAX_N);

  sep_state_e state_q, state_d;

  logic [CFG_W-1:0]    set_size_q, set_size_d;
  logic                done_q, done_d;
  logic [SEQ_W-1:0]    count_q, count_d;
  logic [DIG_W-1:0]    m_q, m_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic                issue_q, issue_d;
  logic                rvld_q, rvld_d;
  logic [AW-1:0]       raddr_q, raddr_d;
  logic                exh_q, exh_d;
  logic [DIGITS_W-1:0] packed_q, packed_d;
  logic                found_q, found_d;
  logic [AW-1:0]       j_q, j_d;
  logic [DIG_W-1:0]    jd_q, jd_d;
  logic [DIG_W-1:0]    jb_q, jb_d;
  logic [DIG_W-1:0]    tail_dig_q, tail_dig_d;
  logic                tail_at_bnd_q, tail_at_bnd_d;
  logic [DIG_W-1:0]    wdig_q, wdig_d;
  logic                first_q, first_d;

  logic                out_valid_q, out_valid_d;
  logic [DIGITS_W-1:0] out_digits_q, out_digits_d;
  logic [SEQ_W-1:0]    out_seq_q, out_seq_d;
  logic                out_last_q, out_last_d;
  logic                out_exh_q, out_exh_d;

  logic [CFG_W-1:0]     n_eff;
  logic [AW-1:0]        n_m1;
  logic                 acc;
  logic                 clear;
  logic                 out_free;
  logic                 last;
  logic                 rd_en;
  sep_wr_t              wr_req;
  logic [DIG_W-1:0]     rd_dig, rd_bnd;
  logic [DIG_IDX_W-1:0] pidx;

  always_comb begin
    if (set_size_q < SET_SIZE_MIN) begin
      n_eff = SET_SIZE_MIN;
    end else if (set_size_q > MaxNCfg) begin
      n_eff = MaxNCfg;
    end else begin
      n_eff = set_size_q;
    end
  end

  assign n_m1     = AW'(n_eff - CFG_W'(1));
  assign acc      = in_valid_i && in_ready_o;
  assign clear    = cfg_we_i || (acc && restart_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign last     = tail_at_bnd_q && !found_q;
  assign pidx     = DIG_IDX_W'(raddr_q) << 2;

  sep_store #(
    .DEPTH (MAX_N),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clear),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .wr_addr_i (addr_q),
    .wr_i      (wr_req),
    .rd_dig_o  (rd_dig),
    .rd_bnd_o  (rd_bnd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) state_d = (done_q && !restart_i) ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (rvld_q && (raddr_q == '0)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = (exh_q || last) ? ST_IDLE : ST_WRITE;
      end
      ST_WRITE: begin
        if (addr_q == n_m1) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: handshake, read port and write port.
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    wr_req     = '0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SCAN: rd_en = issue_q;
      ST_EMIT: ;
      ST_WRITE: begin
        wr_req.dig_en = 1'b1;
        if (first_q) begin
          wr_req.dig = wdig_q;
        end else begin
          wr_req.bnd_en = 1'b1;
          wr_req.dig    = '0;
          wr_req.bnd    = m_q;
        end
      end
      default: ;
    endcase
  end

  // Datapath.
  always_comb begin
    set_size_d    = set_size_q;
    done_d        = done_q;
    count_d       = count_q;
    m_d           = m_q;
    addr_d        = addr_q;
    issue_d       = issue_q;
    rvld_d        = 1'b0;
    raddr_d       = raddr_q;
    exh_d         = exh_q;
    packed_d      = packed_q;
    found_d       = found_q;
    j_d           = j_q;
    jd_d          = jd_q;
    jb_d          = jb_q;
    tail_dig_d    = tail_dig_q;
    tail_at_bnd_d = tail_at_bnd_q;
    wdig_d        = wdig_q;
    first_d       = first_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_digits_d  = out_digits_q;
    out_seq_d     = out_seq_q;
    out_last_d    = out_last_q;
    out_exh_d     = out_exh_q;

    if (cfg_we_i) set_size_d = cfg_wdata_i;
    if (clear) begin
      done_d  = 1'b0;
      count_d = '0;
      m_d     = BOUND_RESET;
    end

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          exh_d    = done_q && !restart_i;
          addr_d   = n_m1;
          issue_d  = !(done_q && !restart_i);
          packed_d = '0;
          found_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (issue_q) begin
          rvld_d  = 1'b1;
          raddr_d = addr_q;
          if (addr_q == '0) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q - AW'(1);
          end
        end
        if (rvld_q) begin
          packed_d[pidx +: DIG_W] = rd_dig;
          if (raddr_q == n_m1) begin
            tail_dig_d    = rd_dig;
            tail_at_bnd_d = (rd_dig == m_q);
          end else if ((raddr_q != '0) && !found_q && (rd_dig != rd_bnd)) begin
            // first hit in a descending scan is the rightmost one
            found_d = 1'b1;
            j_d     = raddr_q;
            jd_d    = rd_dig;
            jb_d    = rd_bnd;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_exh_d   = exh_q;
          if (exh_q) begin
            out_digits_d = '0;
            out_seq_d    = '0;
            out_last_d   = 1'b0;
          end else begin
            out_digits_d = packed_q;
            out_seq_d    = count_q;
            out_last_d   = last;
            count_d      = count_q + SEQ_W'(1);
            if (last) begin
              done_d = 1'b1;
            end else begin
              first_d = 1'b1;
              if (tail_at_bnd_q) begin
                wdig_d = jd_q + DIG_W'(1);
                addr_d = j_q;
              end else begin
                wdig_d = tail_dig_q + DIG_W'(1);
                addr_d = n_m1;
              end
            end
          end
        end
      end
      ST_WRITE: begin
        first_d = 1'b0;
        if (first_q && tail_at_bnd_q) begin
          m_d = jb_q + DIG_W'(wdig_q == jb_q);
        end
        if (addr_q != n_m1) addr_d = addr_q + AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      set_size_q  <= SET_SIZE_RESET;
      done_q      <= 1'b0;
      count_q     <= '0;
      m_q         <= BOUND_RESET;
      issue_q     <= 1'b0;
      rvld_q      <= 1'b0;
      exh_q       <= 1'b0;
      found_q     <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      set_size_q  <= set_size_d;
      done_q      <= done_d;
      count_q     <= count_d;
      m_q         <= m_d;
      issue_q     <= issue_d;
      rvld_q      <= rvld_d;
      exh_q       <= exh_d;
      found_q     <= found_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q        <= addr_d;
    raddr_q       <= raddr_d;
    packed_q      <= packed_d;
    j_q           <= j_d;
    jd_q          <= jd_d;
    jb_q          <= jb_d;
    tail_dig_q    <= tail_dig_d;
    tail_at_bnd_q <= tail_at_bnd_d;
    wdig_q        <= wdig_d;
    out_digits_q  <= out_digits_d;
    out_seq_q     <= out_seq_d;
    out_last_q    <= out_last_d;
    out_exh_q     <= out_exh_d;
  end

  assign out_valid_o       = out_valid_q;
  assign growth_digits_o   = out_digits_q;
  assign sequence_number_o = out_seq_q;
  assign is_last_o         = out_last_q;
  assign exhausted_o       = out_exh_q;

  a_exh_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |-> (growth_digits_o == '0) && (sequence_number_o == '0)
      && !is_last_o)
    else $error("exhausted result carries nonzero fields");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (addr_q <= n_m1))
    else $error("write-back ran past the final digit");

  a_found_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && found_q |-> (j_q != '0) && (j_q < n_m1))
    else $error("scan picked an index outside the inner digits");

  a_exh_skip_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && done_q && !restart_i |=> (state_q == ST_EMIT) && exh_q)
    else $error("request after exhaustion did not go straight to emit");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> out_valid_o && is_last_o)
    else $error("enumeration ended without emitting the last string");

endmodule

`default_nettype wire
